// ----- hdl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int PRIO_W = 32;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_CHANGE = 3'd2,
    CMD_POP    = 3'd3,
    CMD_LOOKUP = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY_POP = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic del_en;   // close the gap: cells at or past the victim take from next
    logic ins_en;   // open a gap: cells below the new priority take from prev
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/spq_prefix.sv -----
// ----------------------------------------------------------------------------
// spq_prefix
// Log-depth running OR from the head: y[i] = x[0] | ... | x[i].
// ----------------------------------------------------------------------------
`default_nettype none

module spq_prefix #(
  parameter int N = 16
) (
  input  wire logic [N-1:0] x,
  output logic      [N-1:0] y
);

  localparam int LVLS = $clog2(N);

  logic [N-1:0] lvl [0:LVLS];

  assign lvl[0] = x;

  for (genvar k = 0; k < LVLS; k++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign y = lvl[LVLS];

endmodule

`default_nettype wire

// ----- hdl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: holds an entry and moves it toward head or tail.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
  parameter int LABEL_BITS = 16
) (
  input  wire logic                         clk,
  input  wire spq_pkg::cell_ctl_t           ctl,
  input  wire logic                         occupied,
  input  wire logic                         rm,        // at or past delete point
  input  wire logic                         ge_prev,   // previous slot stays put
  input  wire logic [LABEL_BITS-1:0]        key_label,
  input  wire logic signed [spq_pkg::PRIO_W-1:0] key_pri,
  input  wire logic [LABEL_BITS-1:0]        next_label,
  input  wire logic signed [spq_pkg::PRIO_W-1:0] next_pri,
  input  wire logic [LABEL_BITS-1:0]        prev_label,
  input  wire logic signed [spq_pkg::PRIO_W-1:0] prev_pri,
  output logic [LABEL_BITS-1:0]             slot_label,
  output logic signed [spq_pkg::PRIO_W-1:0] slot_pri,
  output logic                              match,
  output logic                              ge
);

  import spq_pkg::*;

  assign match = occupied && (slot_label == key_label);
  // ties keep the older entry ahead
  assign ge    = occupied && (slot_pri >= key_pri);

  always_ff @(posedge clk) begin
    if (ctl.del_en && rm) begin
      slot_label <= next_label;
      slot_pri   <= next_pri;
    end else if (ctl.ins_en && !ge) begin
      if (ge_prev) begin
        slot_label <= key_label;
        slot_pri   <= key_pri;
      end else begin
        slot_label <= prev_label;
        slot_pri   <= prev_pri;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a row of shift cells, largest first.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | word
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | cmd, label, priority_req
//  out     | out_valid / out_ready| status, found, popped_*, count, is_empty,
//          |                      | head_*, tail_*
//
//  A command runs in order from accept to result: accept, a delete pass
//  (label search through a log-depth prefix, row shifts toward head), an
//  insert pass (row shifts toward tail below the new priority), and a report
//  cycle that picks head and tail. The row is updated only in those passes.
//  Reset clears the entry count and the control; slot contents need none.
//  A result not yet taken holds the report cycle; in_ready stays low until
//  the block is back in idle, so a stalled output backs up the input.
//
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH      = 16,
  parameter int LABEL_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    cmd,
  input  wire logic [LABEL_BITS-1:0]         label,
  input  wire logic signed [spq_pkg::PRIO_W-1:0] priority_req,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic                               found,
  output logic [LABEL_BITS-1:0]              popped_label,
  output logic signed [spq_pkg::PRIO_W-1:0]  popped_priority,
  output logic [$clog2(DEPTH+1)-1:0]         count,
  output logic                               is_empty,
  output logic [LABEL_BITS-1:0]              head_label,
  output logic signed [spq_pkg::PRIO_W-1:0]  head_priority,
  output logic [LABEL_BITS-1:0]              tail_label,
  output logic signed [spq_pkg::PRIO_W-1:0]  tail_priority
);

  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEL  = 4'b0010,
    S_INS  = 4'b0100,
    S_RPT  = 4'b1000
  } state_t;

  state_t state, state_next;

  // latched command word
  logic [2:0]                  cmd_q;
  logic [LABEL_BITS-1:0]       lab_q;
  logic signed [PRIO_W-1:0]    pri_q;

  logic [CNT_W-1:0]            occ, occ_next;
  logic                        found_q;
  logic [1:0]                  stat_q;
  logic [LABEL_BITS-1:0]       pop_lab_q;
  logic signed [PRIO_W-1:0]    pop_pri_q;

  // cell row
  logic [LABEL_BITS-1:0]       c_label [DEPTH];
  logic signed [PRIO_W-1:0]    c_pri   [DEPTH];
  logic [DEPTH-1:0]            c_occ, c_match, c_ge, c_rm, match_pre;
  cell_ctl_t                   ctl;

  logic                        any_match, is_full, do_del, is_pop, do_ins;
  logic [LABEL_BITS-1:0]       tail_lab_sel;
  logic signed [PRIO_W-1:0]    tail_pri_sel;

  assign in_ready = (state == S_IDLE);

  // occupancy mask from the count
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      c_occ[i] = (CNT_W'(i) < occ);
    end
  end

  spq_prefix #(.N(DEPTH)) u_prefix (
    .x (c_match),
    .y (match_pre)
  );

  assign any_match = match_pre[DEPTH-1];
  assign is_full   = (occ == CNT_W'(DEPTH));
  assign is_pop    = (cmd_q == CMD_POP);
  assign do_del    = (state == S_DEL) &&
                     ((((cmd_q == CMD_DELETE) || (cmd_q == CMD_CHANGE)) && any_match) ||
                      (is_pop && (occ != '0)));
  assign do_ins    = (state == S_INS) && !is_full &&
                     ((cmd_q == CMD_INSERT) || (cmd_q == CMD_CHANGE));

  // pop removes the head: every slot shifts
  assign c_rm       = is_pop ? '1 : match_pre;
  assign ctl.del_en = do_del;
  assign ctl.ins_en = do_ins;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [LABEL_BITS-1:0]    nxt_l, prv_l;
    logic signed [PRIO_W-1:0] nxt_p, prv_p;
    logic                     gep;

    if (i == DEPTH - 1) begin : g_last
      assign nxt_l = c_label[i];
      assign nxt_p = c_pri[i];
    end else begin : g_mid
      assign nxt_l = c_label[i+1];
      assign nxt_p = c_pri[i+1];
    end

    if (i == 0) begin : g_first
      assign prv_l = c_label[i];
      assign prv_p = c_pri[i];
      assign gep   = 1'b1;
    end else begin : g_rest
      assign prv_l = c_label[i-1];
      assign prv_p = c_pri[i-1];
      assign gep   = c_ge[i-1];
    end

    spq_cell #(.LABEL_BITS(LABEL_BITS)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (c_occ[i]),
      .rm         (c_rm[i]),
      .ge_prev    (gep),
      .key_label  (lab_q),
      .key_pri    (pri_q),
      .next_label (nxt_l),
      .next_pri   (nxt_p),
      .prev_label (prv_l),
      .prev_pri   (prv_p),
      .slot_label (c_label[i]),
      .slot_pri   (c_pri[i]),
      .match      (c_match[i]),
      .ge         (c_ge[i])
    );
  end

  // tail: the one slot whose index is count-1 (AND-OR select)
  always_comb begin
    tail_lab_sel = '0;
    tail_pri_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i + 1) == occ) begin
        tail_lab_sel = tail_lab_sel | c_label[i];
        tail_pri_sel = tail_pri_sel | c_pri[i];
      end
    end
  end

  always_comb begin
    state_next = state;
    occ_next   = occ;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DEL;
      S_DEL: begin
        state_next = S_INS;
        if (do_del) occ_next = occ - CNT_W'(1);
      end
      S_INS: begin
        state_next = S_RPT;
        if (do_ins) occ_next = occ + CNT_W'(1);
      end
      S_RPT: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (state == S_RPT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // command word and per-command results
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q <= cmd;
      lab_q <= label;
      pri_q <= priority_req;
    end

    if (state == S_DEL) begin
      found_q   <= any_match;
      pop_lab_q <= (is_pop && (occ != '0)) ? c_label[0] : '0;
      pop_pri_q <= (is_pop && (occ != '0)) ? c_pri[0] : '0;
      case (cmd_q)
        CMD_DELETE, CMD_CHANGE, CMD_LOOKUP:
          stat_q <= any_match ? ST_OK : ST_NOT_FOUND;
        CMD_POP: begin
          if (occ == '0) begin
            stat_q <= ST_EMPTY_POP;
          end else begin
            stat_q <= ST_OK;
          end
        end
        default: stat_q <= ST_OK;
      endcase
    end

    // full check after any delete of the same command
    if (state == S_INS && is_full &&
        ((cmd_q == CMD_INSERT) || (cmd_q == CMD_CHANGE))) begin
      stat_q <= ST_FULL;
    end

    if (state == S_RPT && (!out_valid || out_ready)) begin
      status          <= stat_q;
      found           <= found_q;
      popped_label    <= pop_lab_q;
      popped_priority <= pop_pri_q;
      count           <= occ;
      is_empty        <= (occ == '0);
      head_label      <= (occ == '0) ? '0 : c_label[0];
      head_priority   <= (occ == '0) ? '0 : c_pri[0];
      tail_label      <= tail_lab_sel;
      tail_priority   <= tail_pri_sel;
    end
  end

endmodule

`default_nettype wire
